// ===== sv/ternary_noisy_prototype_sampler_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ternary noisy-prototype sampler
// Concurrent checks on clk, disabled while rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef TERNARY_NOISY_PROTOTYPE_SAMPLER_UNIT_ASSERT_SVH
`define TERNARY_NOISY_PROTOTYPE_SAMPLER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication
`define TNPS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define TNPS_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`ifndef SYNTH
// Next-cycle implication
`define TNPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TNPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/tnps_pkg.sv =====
// ----------------------------------------------------------------------------
// tnps_pkg
// Constants, codes and the xorshift32 step shared by the sampler.
// ----------------------------------------------------------------------------
package tnps_pkg;

    // Sizing
    localparam int MAX_CLASSES = 16;
    localparam int MAX_DIM     = 64;
    localparam int CLS_W       = $clog2(MAX_CLASSES);
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int MEM_DEPTH   = MAX_CLASSES * MAX_DIM;
    localparam int MEM_AW      = CLS_W + DIM_W;

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [2:0] REG_CLASS_COUNT = 3'd0;
    localparam logic [2:0] REG_DIMENSION   = 3'd1;
    localparam logic [2:0] REG_INFO_COUNT  = 3'd2;
    localparam logic [2:0] REG_NOISE_PCT   = 3'd3;
    localparam logic [2:0] REG_BASE_SEED   = 3'd4;

    localparam logic [4:0]  CLASS_COUNT_RST = 5'd10;
    localparam logic [6:0]  DIMENSION_RST   = 7'd64;
    localparam logic [6:0]  INFO_COUNT_RST  = 7'd16;
    localparam logic [6:0]  NOISE_PCT_RST   = 7'd10;
    localparam logic [31:0] BASE_SEED_RST   = 32'hdeadbeef;

    // Request commands
    localparam logic [1:0] CMD_BUILD  = 2'd0;
    localparam logic [1:0] CMD_RESEED = 2'd1;
    localparam logic [1:0] CMD_NEXT   = 2'd2;

    localparam logic [31:0] SEED_MIX = 32'h5a5a5a5a;

    // Label remainder unit: two dividend bits per step
    localparam int REM_W     = 7;
    localparam int MOD_STEPS = 32 / 2;
    localparam int CNT_W     = $clog2(MOD_STEPS);
    localparam logic [REM_W-1:0] PCT_DIV   = 7'd100;
    localparam logic [REM_W-1:0] TRI_DIV   = 7'd3;

    // Reciprocals for the fixed divisors: q = (x * RECIP) >> SHIFT
    localparam logic [31:0] RECIP_PCT = 32'h51eb851f;
    localparam logic [31:0] RECIP_TRI = 32'haaaaaaab;
    localparam int          PCT_SHIFT = 37;
    localparam int          TRI_SHIFT = 33;

    // Trit codes
    localparam logic signed [1:0] TRIT_NEG  = 2'sb11;
    localparam logic signed [1:0] TRIT_ZERO = 2'sb00;
    localparam logic signed [1:0] TRIT_POS  = 2'sb01;

    // One xorshift32 step (13, 17, 5)
    function automatic logic [31:0] xs32(input logic [31:0] s);
        logic [31:0] x;
        x = s ^ (s << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

// ===== sv/ternary_noisy_prototype_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// ternary_noisy_prototype_sampler_unit
// Ternary test-vector generator with per-class prototypes and noisy sampling.
// ----------------------------------------------------------------------------
// One request at a time; req_stall is high from the accepting edge until the
// request is done. A build request writes one prototype sign per cycle,
// effective class count * effective informative count signs in all (no
// results). A sample first draws the label, whose remainder by the class
// count comes from a radix-4 remainder unit, then makes each trit in turn:
// one xorshift32 step, a reciprocal multiply for the mod 100 or mod 3,
// forming the trit (one more draw when an informative trit flips) and
// handing it over, which waits while the result is stalled. The next
// request can be taken in the cycle after the last trit leaves. Every draw
// goes through the single xorshift32 unit.
// ----------------------------------------------------------------------------
`include "ternary_noisy_prototype_sampler_unit_assert.svh"

module ternary_noisy_prototype_sampler_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tnps_pkg::PADDR_W-1:0]       paddr,
    input  logic [tnps_pkg::PDATA_W-1:0]       pwdata,
    output logic [tnps_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    // Request channel
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [1:0]                         cmd,
    input  logic [31:0]                        mix_seed,
    // Result channel
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic [3:0]                         label,
    output logic [5:0]                         position,
    output logic signed [1:0]                  trit,
    output logic                               last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_LABEL,
        S_TRIT,
        S_MOD,
        S_USE,
        S_FLIP,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        K_LABEL,
        K_PCT,
        K_TRI
    } mod_kind_t;

    // Configuration registers
    logic [4:0]  class_count_reg, class_count_next;
    logic [6:0]  dimension_reg, dimension_next;
    logic [6:0]  info_count_reg, info_count_next;
    logic [6:0]  noise_pct_reg, noise_pct_next;
    logic [31:0] base_seed_reg, base_seed_next;

    // Sequencer and datapath registers
    state_t                        state_reg, state_next;
    mod_kind_t                     kind_reg, kind_next;
    logic [31:0]                   rng_reg, rng_next;
    logic [31:0]                   build_rng_reg, build_rng_next;
    logic [tnps_pkg::CLS_W-1:0]    cls_reg, cls_next;
    logic [tnps_pkg::DIM_W-1:0]    j_reg, j_next;
    logic [3:0]                    label_reg, label_next;
    logic signed [1:0]             trit_reg, trit_next;
    logic                          last_reg, last_next;
    logic                          res_valid_reg, res_valid_next;

    // Remainder unit
    logic [31:0]                   val_reg, val_next;
    logic [tnps_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [tnps_pkg::REM_W-1:0]    div_reg, div_next;
    logic [tnps_pkg::REM_W+1:0]    div3_reg, div3_next;
    logic [tnps_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [63:0]                   prod_reg, prod_next;

    // Prototype sign memory
    logic                          mem [tnps_pkg::MEM_DEPTH];
    logic                          mem_q_reg;
    logic                          mem_we;
    logic [tnps_pkg::MEM_AW-1:0]   mem_waddr;
    logic [tnps_pkg::MEM_AW-1:0]   mem_raddr;

    // Effective configuration
    logic [4:0] nc_eff;
    logic [6:0] d_eff;
    logic [6:0] k_eff;

    logic                          cfg_we;
    logic [31:0]                   xs_src;
    logic [31:0]                   xs_out;
    logic [tnps_pkg::REM_W+1:0]    step_acc;
    logic [tnps_pkg::REM_W+1:0]    step_r;
    logic [31:0]                   recip_sel;
    logic [31:0]                   quot;
    logic [31:0]                   fold_rem;
    logic                          proto_pos;

    // Clamp the configuration to the supported ranges
    always_comb
    begin
        if (class_count_reg == 5'd0)
            nc_eff = 5'd1;
        else if (32'(class_count_reg) > tnps_pkg::MAX_CLASSES)
            nc_eff = 5'(tnps_pkg::MAX_CLASSES);
        else
            nc_eff = class_count_reg;

        if (dimension_reg == 7'd0)
            d_eff = 7'd1;
        else if (32'(dimension_reg) > tnps_pkg::MAX_DIM)
            d_eff = 7'(tnps_pkg::MAX_DIM);
        else
            d_eff = dimension_reg;

        k_eff = (info_count_reg > d_eff) ? d_eff : info_count_reg;
    end

    // Shared xorshift step
    assign xs_src = (state_reg == S_BUILD) ? build_rng_reg : rng_reg;
    assign xs_out = tnps_pkg::xs32(xs_src);

    // Remainder step: bring in two bits, subtract up to three divisors
    always_comb
    begin
        step_acc = {rem_reg, val_reg[31:30]};
        if (step_acc >= div3_reg)
            step_r = step_acc - div3_reg;
        else if (step_acc >= {1'b0, div_reg, 1'b0})
            step_r = step_acc - {1'b0, div_reg, 1'b0};
        else if (step_acc >= {2'b00, div_reg})
            step_r = step_acc - {2'b00, div_reg};
        else
            step_r = step_acc;
    end

    // Fixed divisors: reciprocal product, then fold back to the remainder
    assign recip_sel = (kind_reg == K_PCT) ? tnps_pkg::RECIP_PCT : tnps_pkg::RECIP_TRI;

    always_comb
    begin
        if (kind_reg == K_PCT)
        begin
            quot     = 32'(prod_reg >> tnps_pkg::PCT_SHIFT);
            fold_rem = val_reg - quot * 32'(tnps_pkg::PCT_DIV);
        end
        else
        begin
            quot     = 32'(prod_reg >> tnps_pkg::TRI_SHIFT);
            fold_rem = val_reg - quot * 32'(tnps_pkg::TRI_DIV);
        end
    end

    // Prototype memory: one write port, one registered read port
    assign mem_raddr = {label_reg[tnps_pkg::CLS_W-1:0], j_reg};
    assign mem_waddr = {cls_reg, j_reg};
    assign proto_pos = mem_q_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= xs_out[0];
        end
        mem_q_reg <= mem[mem_raddr];
    end

    // Configuration port
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_comb
    begin
        unique case (paddr[4:2])
            tnps_pkg::REG_CLASS_COUNT: prdata = {27'd0, class_count_reg};
            tnps_pkg::REG_DIMENSION:   prdata = {25'd0, dimension_reg};
            tnps_pkg::REG_INFO_COUNT:  prdata = {25'd0, info_count_reg};
            tnps_pkg::REG_NOISE_PCT:   prdata = {25'd0, noise_pct_reg};
            tnps_pkg::REG_BASE_SEED:   prdata = base_seed_reg;
            default:                   prdata = '0;
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        class_count_next = class_count_reg;
        dimension_next   = dimension_reg;
        info_count_next  = info_count_reg;
        noise_pct_next   = noise_pct_reg;
        base_seed_next   = base_seed_reg;
        state_next       = state_reg;
        kind_next        = kind_reg;
        rng_next         = rng_reg;
        build_rng_next   = build_rng_reg;
        cls_next         = cls_reg;
        j_next           = j_reg;
        label_next       = label_reg;
        trit_next        = trit_reg;
        last_next        = last_reg;
        res_valid_next   = res_valid_reg;
        val_next         = val_reg;
        rem_next         = rem_reg;
        div_next         = div_reg;
        div3_next        = div3_reg;
        cnt_next         = cnt_reg;
        prod_next        = prod_reg;
        mem_we           = 1'b0;

        // register writes
        if (cfg_we)
        begin
            unique case (paddr[4:2])
                tnps_pkg::REG_CLASS_COUNT: class_count_next = pwdata[4:0];
                tnps_pkg::REG_DIMENSION:   dimension_next   = pwdata[6:0];
                tnps_pkg::REG_INFO_COUNT:  info_count_next  = pwdata[6:0];
                tnps_pkg::REG_NOISE_PCT:   noise_pct_next   = pwdata[6:0];
                tnps_pkg::REG_BASE_SEED:   base_seed_next   = pwdata;
                default:                   ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (cmd)
                        tnps_pkg::CMD_BUILD:
                        begin
                            if (k_eff != 7'd0)
                            begin
                                build_rng_next = base_seed_reg;
                                cls_next       = '0;
                                j_next         = '0;
                                state_next     = S_BUILD;
                            end
                        end
                        tnps_pkg::CMD_RESEED:
                        begin
                            rng_next   = base_seed_reg ^ mix_seed ^ tnps_pkg::SEED_MIX;
                            state_next = S_LABEL;
                        end
                        tnps_pkg::CMD_NEXT:
                        begin
                            state_next = S_LABEL;
                        end
                        default: ;
                    endcase
                end
            end

            // one prototype sign per cycle
            S_BUILD:
            begin
                build_rng_next = xs_out;
                mem_we         = 1'b1;
                if ({1'b0, j_reg} == k_eff - 7'd1)
                begin
                    j_next = '0;
                    if ({1'b0, cls_reg} == nc_eff - 5'd1)
                        state_next = S_IDLE;
                    else
                        cls_next = cls_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end

            // label draw: rand mod class count
            S_LABEL:
            begin
                rng_next   = xs_out;
                val_next   = xs_out;
                rem_next   = '0;
                cnt_next   = '0;
                div_next   = {2'b00, nc_eff};
                div3_next  = {4'b0000, nc_eff} + {3'b000, nc_eff, 1'b0};
                kind_next  = K_LABEL;
                state_next = S_MOD;
            end

            // trit draw: mod 100 for informative, mod 3 for noise
            S_TRIT:
            begin
                rng_next   = xs_out;
                val_next   = xs_out;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_MOD;
                if ({1'b0, j_reg} < k_eff)
                    kind_next = K_PCT;
                else
                    kind_next = K_TRI;
            end

            // label: radix-4 steps; fixed divisors: multiply, then fold
            S_MOD:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (kind_reg == K_LABEL)
                begin
                    rem_next = step_r[tnps_pkg::REM_W-1:0];
                    val_next = val_reg << 2;
                    if (cnt_reg == tnps_pkg::CNT_W'(tnps_pkg::MOD_STEPS - 1))
                        state_next = S_USE;
                end
                else if (cnt_reg == '0)
                begin
                    prod_next = {32'd0, val_reg} * {32'd0, recip_sel};
                end
                else
                begin
                    rem_next   = fold_rem[tnps_pkg::REM_W-1:0];
                    state_next = S_USE;
                end
            end

            S_USE:
            begin
                unique case (kind_reg)
                    K_LABEL:
                    begin
                        label_next = rem_reg[3:0];
                        j_next     = '0;
                        state_next = S_TRIT;
                    end
                    K_PCT:
                    begin
                        if (rem_reg < noise_pct_reg)
                        begin
                            state_next = S_FLIP;
                        end
                        else
                        begin
                            trit_next      = proto_pos ? tnps_pkg::TRIT_POS : tnps_pkg::TRIT_NEG;
                            res_valid_next = 1'b1;
                            last_next      = ({1'b0, j_reg} == d_eff - 7'd1);
                            state_next     = S_OUT;
                        end
                    end
                    default:
                    begin
                        case (rem_reg)
                            7'd0:    trit_next = tnps_pkg::TRIT_NEG;
                            7'd1:    trit_next = tnps_pkg::TRIT_ZERO;
                            default: trit_next = tnps_pkg::TRIT_POS;
                        endcase
                        res_valid_next = 1'b1;
                        last_next      = ({1'b0, j_reg} == d_eff - 7'd1);
                        state_next     = S_OUT;
                    end
                endcase
            end

            // flipped trit: low bit picks zero or the opposite sign
            S_FLIP:
            begin
                rng_next = xs_out;
                if (xs_out[0])
                    trit_next = tnps_pkg::TRIT_ZERO;
                else
                    trit_next = proto_pos ? tnps_pkg::TRIT_NEG : tnps_pkg::TRIT_POS;
                res_valid_next = 1'b1;
                last_next      = ({1'b0, j_reg} == d_eff - 7'd1);
                state_next     = S_OUT;
            end

            // hold the result until taken
            S_OUT:
            begin
                if (!res_stall)
                begin
                    res_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_TRIT;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg <= tnps_pkg::CLASS_COUNT_RST;
            dimension_reg   <= tnps_pkg::DIMENSION_RST;
            info_count_reg  <= tnps_pkg::INFO_COUNT_RST;
            noise_pct_reg   <= tnps_pkg::NOISE_PCT_RST;
            base_seed_reg   <= tnps_pkg::BASE_SEED_RST;
            state_reg       <= S_IDLE;
            kind_reg        <= K_LABEL;
            rng_reg         <= '0;
            build_rng_reg   <= '0;
            cls_reg         <= '0;
            j_reg           <= '0;
            label_reg       <= '0;
            trit_reg        <= tnps_pkg::TRIT_ZERO;
            last_reg        <= 1'b0;
            res_valid_reg   <= 1'b0;
            val_reg         <= '0;
            rem_reg         <= '0;
            div_reg         <= 7'd1;
            div3_reg        <= 9'd3;
            cnt_reg         <= '0;
            prod_reg        <= '0;
        end
        else
        begin
            class_count_reg <= class_count_next;
            dimension_reg   <= dimension_next;
            info_count_reg  <= info_count_next;
            noise_pct_reg   <= noise_pct_next;
            base_seed_reg   <= base_seed_next;
            state_reg       <= state_next;
            kind_reg        <= kind_next;
            rng_reg         <= rng_next;
            build_rng_reg   <= build_rng_next;
            cls_reg         <= cls_next;
            j_reg           <= j_next;
            label_reg       <= label_next;
            trit_reg        <= trit_next;
            last_reg        <= last_next;
            res_valid_reg   <= res_valid_next;
            val_reg         <= val_next;
            rem_reg         <= rem_next;
            div_reg         <= div_next;
            div3_reg        <= div3_next;
            cnt_reg         <= cnt_next;
            prod_reg        <= prod_next;
        end
    end

    // Ports
    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign label     = label_reg;
    assign position  = j_reg;
    assign trit      = trit_reg;
    assign last      = last_reg;

    // Checks
    `TNPS_ASSERT_IMPL(a_req_res_excl, !req_stall, !res_valid, "request taken with result up")
    `TNPS_ASSERT_NEXT(a_mod_done, (state_reg == S_MOD) && (cnt_reg == 4'd15), state_reg == S_USE, "mod overran")
    `TNPS_ASSERT_IMPL(a_last_pos, res_valid_reg && last_reg, {1'b0, j_reg} == d_eff - 7'd1, "bad last")
    `TNPS_ASSERT_IMPL(a_label_rng, res_valid_reg, {1'b0, label_reg} < nc_eff, "label too big")

endmodule
